>>> rtl/psg_tone_noise_generator_assert.svh
// Assertion macros shared by the sound generator RTL.
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define PSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/psg_pkg.sv
// Package with types, codes and the level table of the sound generator.
`default_nettype none
package psg_pkg;
  localparam int unsigned NumCh     = 4;
  localparam int unsigned CountW    = 22;
  localparam int unsigned ProdW     = 31;
  localparam int unsigned QuoW      = 16;

  localparam logic [1:0] CfgStep    = 2'd0;
  localparam logic [1:0] CfgVolume  = 2'd1;
  localparam logic [1:0] CfgVariant = 2'd2;
  localparam logic [1:0] CfgMute    = 2'd3;

  localparam logic [2:0] RegNoise   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOL,
    ST_UPD,
    ST_DIV,
    ST_AMP,
    ST_DONE
  } state_e;

  // Attenuation to Q1.16 gain, 2 dB per step, last entry silent.
  function automatic logic [16:0] level_rom(input logic [3:0] att);
    logic [16:0] v;
    case (att)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd52057;
      4'd2:    v = 17'd41350;
      4'd3:    v = 17'd32846;
      4'd4:    v = 17'd26090;
      4'd5:    v = 17'd20724;
      4'd6:    v = 17'd16462;
      4'd7:    v = 17'd13076;
      4'd8:    v = 17'd10387;
      4'd9:    v = 17'd8250;
      4'd10:   v = 17'd6554;
      4'd11:   v = 17'd5206;
      4'd12:   v = 17'd4135;
      4'd13:   v = 17'd3285;
      4'd14:   v = 17'd2609;
      default: v = 17'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/psg_tone_noise_generator.sv
// Top level of the four-channel tone and noise sound generator.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o    opcode_i, data_byte_i
// out       output     out_valid_o / out_ready_i  sample_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A sample tick walks the four channels in turn: a volume step and an update step
// each, plus the divide and amplitude steps for a channel whose edge is smoothed,
// where the bit-serial divider resolves one quotient bit a cycle. A muted tick
// goes straight to the done state. Reset clears the control and channel state.
// A stalled output holds the finished sample; write bytes are still taken while idle.
`default_nettype none
module psg_tone_noise_generator
  import psg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [17:0]      sample_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i
);
  `include "psg_tone_noise_generator_assert.svh"

  // Configuration registers.
  logic [15:0] step_q;
  logic [14:0] full_vol_q;
  logic        variant_q, mute_q;

  // Register file and channel state.
  logic [9:0]        tone_reg_q [3];
  logic [2:0]        tone_set_q;
  logic [3:0]        att_q [NumCh];
  logic [2:0]        noise_ctrl_q;
  logic              noise_set_q;
  logic [2:0]        latch_q;
  logic [CountW-1:0] count_q [NumCh];
  logic [NumCh-1:0]  level_q;
  logic [16:0]       shift_q;

  // Sequencer and datapath registers.
  state_e            state_q, state_d;
  logic [1:0]        ch_q;
  logic [14:0]       vol_q;
  logic [ProdW-1:0]  rem_q, dsr_q;
  logic [QuoW-1:0]   quo_q;
  logic [3:0]        div_cnt_q;
  logic              neg_q, prev_q, aa_q;
  logic signed [17:0] sum_q, sample_q;
  logic              out_valid_q;

  logic accept, tick;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign tick        = accept && opcode_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // Effective periods follow the registers directly.
  function automatic logic [11:0] tone_period(input logic set, input logic [9:0] r);
    logic [11:0] p;
    if (!set) p = 12'd1;
    else if (r == 10'd0) p = 12'd1024;
    else p = {2'b00, r};
    return p;
  endfunction

  logic [11:0] period [NumCh];
  always_comb begin
    for (int i = 0; i < 3; i++) period[i] = tone_period(tone_set_q[i], tone_reg_q[i]);
    if (!noise_set_q) period[3] = 12'd1;
    else if (noise_ctrl_q[1:0] == 2'd3) period[3] = {period[2][10:0], 1'b0};
    else period[3] = 12'd32 << noise_ctrl_q[1:0];
  end

  // Per-channel counter step and level change.
  logic [14:0]       vol_c;
  logic signed [23:0] cnt_a, cnt_b;
  logic [CountW-1:0] cnt_new;
  logic              under, new_level, prev_level, aa_c, neg_c;
  logic [16:0]       shift_new, two_p;
  logic [15:0]       mag;
  logic [31:0]       vol_prod;
  logic              fb;
  always_comb begin
    vol_prod   = {2'b00, full_vol_q} * {15'd0, level_rom(att_q[ch_q])};
    vol_c      = vol_prod[30:16];
    prev_level = level_q[ch_q];
    cnt_a      = $signed({2'b00, count_q[ch_q]}) - $signed({8'd0, step_q});
    cnt_b      = cnt_a + $signed({4'd0, period[ch_q], 8'd0});
    under      = cnt_a[23];
    if (!under) cnt_new = cnt_a[CountW-1:0];
    else if (cnt_b[23]) cnt_new = '0;
    else cnt_new = cnt_b[CountW-1:0];
    fb = (variant_q ? shift_q[2] : shift_q[0])
       ^ ((variant_q ? shift_q[3] : shift_q[1]) & noise_ctrl_q[2]);
    shift_new = {1'b0, shift_q[16:1]};
    if (fb) begin
      if (variant_q) shift_new[16] = 1'b1;
      else shift_new[14] = 1'b1;
    end
    if (!under) new_level = prev_level;
    else if (ch_q == 2'd3) new_level = shift_new[0];
    else new_level = !prev_level;
    // Smoothing applies when the level flips inside this sample period.
    aa_c  = (new_level != prev_level) && (count_q[ch_q] < {6'd0, step_q});
    two_p = {count_q[ch_q][15:0], 1'b0};
    neg_c = two_p < {1'b0, step_q};
    mag   = neg_c ? 16'({1'b0, step_q} - two_p) : 16'(two_p - {1'b0, step_q});
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (tick) state_d = mute_q ? ST_DONE : ST_VOL;
      ST_VOL:  state_d = ST_UPD;
      ST_UPD: begin
        if (vol_q == '0 || !aa_c) state_d = (ch_q == 2'd3) ? ST_DONE : ST_VOL;
        else state_d = ST_DIV;
      end
      ST_DIV:  if (div_cnt_q == 4'd0) state_d = ST_AMP;
      ST_AMP:  state_d = (ch_q == 2'd3) ? ST_DONE : ST_VOL;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider step and signed amplitude.
  logic              ge;
  logic [QuoW-1:0]   quo_next;
  logic signed [17:0] amp;
  assign ge       = rem_q >= dsr_q;
  assign quo_next = {quo_q[QuoW-2:0], ge};
  always_comb begin
    amp = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    if (!prev_q) amp = -amp;
  end

  // Control and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= 16'd1300;
      full_vol_q   <= 15'd8191;
      variant_q    <= 1'b1;
      mute_q       <= 1'b0;
      tone_reg_q   <= '{default: '0};
      tone_set_q   <= '0;
      att_q        <= '{default: 4'd15};
      noise_ctrl_q <= '0;
      noise_set_q  <= 1'b0;
      latch_q      <= '0;
      count_q      <= '{default: '0};
      level_q      <= '0;
      shift_q      <= 17'h10000;
      ch_q         <= '0;
      div_cnt_q    <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new sample in the done state takes over the output register instead.
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStep:    step_q <= cfg_wdata_i;
          CfgVolume:  full_vol_q <= cfg_wdata_i[14:0];
          CfgVariant: begin
            variant_q  <= cfg_wdata_i[0];
            shift_q    <= cfg_wdata_i[0] ? 17'h10000 : 17'h04000;
            level_q[3] <= 1'b0;
          end
          CfgMute:    mute_q <= cfg_wdata_i[0];
          default:    ;
        endcase
      end
      // Register write bytes.
      if (accept && !opcode_i) begin
        if (data_byte_i[7]) begin
          latch_q <= data_byte_i[6:4];
          if (data_byte_i[6:4] == RegNoise) begin
            noise_ctrl_q <= data_byte_i[2:0];
            noise_set_q  <= 1'b1;
            shift_q      <= variant_q ? 17'h10000 : 17'h04000;
            level_q[3]   <= 1'b0;
          end else if (data_byte_i[4]) begin
            att_q[data_byte_i[6:5]] <= data_byte_i[3:0];
          end else begin
            tone_reg_q[data_byte_i[6:5]][3:0] <= data_byte_i[3:0];
            tone_set_q[data_byte_i[6:5]]      <= 1'b1;
          end
        end else if (!latch_q[0] && latch_q != RegNoise) begin
          tone_reg_q[latch_q[2:1]][9:4] <= data_byte_i[5:0];
          tone_set_q[latch_q[2:1]]      <= 1'b1;
        end
      end
      // Tick sequencing.
      case (state_q)
        ST_IDLE: if (tick) begin
          ch_q  <= '0;
          sum_q <= '0;
        end
        ST_UPD: begin
          if (vol_q != '0) begin
            count_q[ch_q] <= cnt_new;
            level_q[ch_q] <= new_level;
            if (under && ch_q == 2'd3) shift_q <= shift_new;
            if (!aa_c) begin
              sum_q <= prev_level ? sum_q + $signed({3'b000, vol_q})
                                  : sum_q - $signed({3'b000, vol_q});
            end
          end
          if (vol_q == '0 || !aa_c) ch_q <= ch_q + 2'd1;
          else div_cnt_q <= 4'd15;
        end
        ST_DIV: div_cnt_q <= div_cnt_q - 4'd1;
        ST_AMP: begin
          sum_q <= sum_q + amp;
          ch_q  <= ch_q + 2'd1;
        end
        ST_DONE: if (!out_valid_q || out_ready_i) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_VOL) vol_q <= vol_c;
    if (state_q == ST_UPD) begin
      rem_q  <= 31'({16'd0, vol_q} * {15'd0, mag});
      dsr_q  <= {step_q, 15'd0};
      quo_q  <= '0;
      neg_q  <= neg_c;
      prev_q <= prev_level;
      aa_q   <= aa_c;
    end
    if (state_q == ST_DIV) begin
      if (ge) rem_q <= rem_q - dsr_q;
      dsr_q <= {1'b0, dsr_q[ProdW-1:1]};
      quo_q <= quo_next;
    end
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) sample_q <= mute_q ? '0 : sum_q;
  end

  `PSG_ASSERT_NEXT(a_tick_leaves_idle, tick, state_q != ST_IDLE, "tick did not start")
  `PSG_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && div_cnt_q == 4'd0,
                   state_q == ST_AMP, "divider overran")
  `PSG_ASSERT_NOW(a_div_only_smoothed, state_q == ST_DIV, aa_q, "divide without smoothing")
  `PSG_ASSERT_NEXT(a_done_emits, state_q == ST_DONE && !out_valid_q,
                   out_valid_q, "sample not presented")
endmodule
`default_nettype wire
